// ===== hw/rtl/wcl_pkg.sv =====
// Shared types and constants for the wavetable crossfade lookup.
package wcl_pkg;

    localparam int WAVE_LEN      = 256;
    localparam int SAMPLE_W      = 8;
    localparam int BANK_IN_W     = 4;
    localparam int WAVE_IN_W     = 6;
    localparam int TOTAL_W       = 7;
    localparam int POS_W         = 17;
    localparam int FRAC_W        = 16;
    localparam int CFG_W         = 5;
    localparam int S_TDATA_W     = 88;
    localparam int S_TUSER_W     = 2;
    localparam int M_TDATA_W     = 16;
    localparam int SCALED_W      = 24;
    localparam int PROD_W        = 24;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = 2;
    localparam int QCNT_W        = 3;
    localparam int DEF_NUM_BANKS = 16;
    localparam int DEF_MAX_WAVES = 64;

    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1 << FRAC_W);

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_COUNT  = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef struct packed {
        logic                   is_load;
        logic [BANK_IN_W-1:0]   bank;
        logic [WAVE_IN_W-1:0]   wave;
        logic [SAMPLE_W-1:0]    sample_idx;
        logic [SAMPLE_W-1:0]    sample_val;
        logic [SAMPLE_W-1:0]    addr;
        logic [SAMPLE_W-1:0]    merged;
        logic [POS_W-1:0]       pos;
        logic [TOTAL_W-1:0]     nm1;
    } t_cmd;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

endpackage

// ===== hw/rtl/wavetable_crossfade_lookup.sv =====
// Top level of the wavetable crossfade lookup: front end, queue, back end.
//
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: load/count/lookup fields, tuser: func
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: sample_out, merged gates
// cfg       in         i_cfg_we                     i_cfg_wdata: bank_count
//
// One item per cycle sustained while the output is not stalled; a lookup result passes
// through the queue, scaling multiply, wave store read, blend multiply and output registers.
// Loads and count writes produce no result; wave store writes land in item order.
// Reset clears control state and sets every wave count and bank_count to 1.
// The wave store is not cleared; only written entries give defined results.
// An output stall freezes the back end; the front keeps taking transfers until the
// four-entry queue fills.
module wavetable_crossfade_lookup #(
    parameter int NUM_BANKS = wcl_pkg::DEF_NUM_BANKS,
    parameter int MAX_WAVES = wcl_pkg::DEF_MAX_WAVES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wcl_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // bank_choice, wave_index, sample_index, sample_value, wave_total,
    // wave_position, phase_offset, poly_gates, poly_present, single_gates,
    // single_present, zero fill
    input  logic [wcl_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func
    input  logic [wcl_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // sample_out, merged gates
    output logic [wcl_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import wcl_pkg::*;

    logic    push;
    logic    pop;
    logic    c_lookup;
    t_cmd    front_cmd;
    t_cmd    head;
    t_q_stat q_stat;

    wcl_front #(
        .NUM_BANKS (NUM_BANKS),
        .MAX_WAVES (MAX_WAVES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_user      (s_axis_tuser),
        .i_q_full    (q_stat.full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    wcl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    wcl_back #(
        .NUM_BANKS (NUM_BANKS),
        .MAX_WAVES (MAX_WAVES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_stat.empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_c_lookup (c_lookup)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("queue push while full");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            q_stat.count == $past(q_stat.count) + QCNT_W'($past(push)) - QCNT_W'($past(pop)))
        else $error("queue count out of step with push and pop");

    a_out_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(c_lookup))
        else $error("result raised without a lookup in the blend stage");

endmodule

// ===== hw/rtl/wcl_front.sv =====
// Front end: accepts transfers, keeps wave counts and bank count, classifies items.
module wcl_front #(
    parameter int NUM_BANKS = 16,
    parameter int MAX_WAVES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [wcl_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [wcl_pkg::S_TDATA_W-1:0] i_data,
    input  logic [wcl_pkg::S_TUSER_W-1:0] i_user,
    input  logic                         i_q_full,
    output logic                         o_push,
    output wcl_pkg::t_cmd                o_cmd
);
    import wcl_pkg::*;

    localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

    logic [CFG_W-1:0]     r_bank_count;
    logic [TOTAL_W-1:0]   r_counts [NUM_BANKS];

    t_func                func;
    logic [BANK_IN_W-1:0] bank;
    logic [WAVE_IN_W-1:0] wave;
    logic [SAMPLE_W-1:0]  sample_idx;
    logic [SAMPLE_W-1:0]  sample_val;
    logic [TOTAL_W-1:0]   wave_total;
    logic [POS_W-1:0]     wave_pos;
    logic [SAMPLE_W-1:0]  phase;
    logic [SAMPLE_W-1:0]  poly;
    logic                 poly_on;
    logic [SAMPLE_W-1:0]  sg;
    logic [SAMPLE_W-1:0]  sp;

    logic                 accept;
    logic                 load_ok;
    logic                 bank_ok;
    logic [TOTAL_W-1:0]   total_sat;
    logic [8:0]           limit;
    logic [BANK_IN_W-1:0] bank_cl;
    logic [TOTAL_W-1:0]   cnt;
    logic [SAMPLE_W-1:0]  merged;

    always_comb begin
        func       = t_func'(i_user);
        bank       = i_data[3:0];
        wave       = i_data[9:4];
        sample_idx = i_data[17:10];
        sample_val = i_data[25:18];
        wave_total = i_data[32:26];
        wave_pos   = i_data[49:33];
        phase      = i_data[57:50];
        poly       = i_data[65:58];
        poly_on    = i_data[66];
        sg         = i_data[74:67];
        sp         = i_data[82:75];
    end

    always_comb begin
        o_ready = !i_q_full;
        accept  = i_valid && o_ready;
        bank_ok = 32'(bank) < NUM_BANKS;
        load_ok = bank_ok && (32'(wave) < MAX_WAVES);

        if (wave_total == '0) begin
            total_sat = TOTAL_W'(1);
        end else if (32'(wave_total) > MAX_WAVES) begin
            total_sat = TOTAL_W'(MAX_WAVES);
        end else begin
            total_sat = wave_total;
        end

        if (r_bank_count == '0) begin
            limit = 9'd1;
        end else if (32'(r_bank_count) > NUM_BANKS) begin
            limit = 9'(NUM_BANKS);
        end else begin
            limit = 9'(r_bank_count);
        end
        bank_cl = (9'(bank) >= limit) ? BANK_IN_W'(limit - 9'd1) : bank;
        cnt     = r_counts[BANK_W'(bank_cl)];

        merged = ((poly_on ? poly : '0) & ~sp) | (sg & sp);
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.sample_idx = sample_idx;
        o_cmd.sample_val = sample_val;
        o_cmd.wave       = wave;
        o_cmd.merged     = merged;
        o_cmd.addr       = merged + phase;
        o_cmd.pos        = (wave_pos > POS_ONE) ? POS_ONE : wave_pos;
        o_cmd.nm1        = cnt - TOTAL_W'(1);
        o_push           = 1'b0;
        unique case (func)
            FUNC_LOAD: begin
                o_cmd.is_load = 1'b1;
                o_cmd.bank    = bank;
                o_push        = accept && load_ok;
            end
            FUNC_LOOKUP: begin
                o_cmd.is_load = 1'b0;
                o_cmd.bank    = bank_cl;
                o_push        = accept;
            end
            default: begin
                o_cmd.bank = bank;
                o_push     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_count <= CFG_W'(1);
            for (int i = 0; i < NUM_BANKS; i++) begin
                r_counts[i] <= TOTAL_W'(1);
            end
        end else begin
            if (i_cfg_we) begin
                r_bank_count <= i_cfg_wdata;
            end
            if (accept && func == FUNC_COUNT && bank_ok) begin
                r_counts[BANK_W'(bank)] <= total_sat;
            end
        end
    end

endmodule

// ===== hw/rtl/wcl_queue.sv =====
// Short command queue between front end and back end.
module wcl_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wcl_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output wcl_pkg::t_cmd     o_head,
    output wcl_pkg::t_q_stat  o_stat
);
    import wcl_pkg::*;

    t_cmd              r_slots [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_comb begin
        o_head       = r_slots[r_rd_ptr];
        o_stat.full  = (r_count == QCNT_W'(QDEPTH));
        o_stat.empty = (r_count == '0);
        o_stat.count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

endmodule

// ===== hw/rtl/wcl_back.sv =====
// Back end: wave store, position scaling, two-wave blend and output register.
module wcl_back #(
    parameter int NUM_BANKS = 16,
    parameter int MAX_WAVES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  wcl_pkg::t_cmd                 i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [wcl_pkg::M_TDATA_W-1:0] o_data,
    output logic                          o_c_lookup
);
    import wcl_pkg::*;

    localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int WAVE_W = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
    localparam int ADDR_W = BANK_W + WAVE_W + SAMPLE_W;

    logic [SAMPLE_W-1:0] r_mem [2**ADDR_W];

    logic                adv;

    logic                r_a_vld;
    t_cmd                r_a_cmd;
    logic [SCALED_W-1:0] r_a_scaled;

    logic [7:0]          w0;
    logic [7:0]          wsel;
    logic                blend;
    logic [ADDR_W-1:0]   rd_addr_lo;
    logic [ADDR_W-1:0]   rd_addr_hi;
    logic [ADDR_W-1:0]   wr_addr;

    logic                r_b_vld;
    logic [SAMPLE_W-1:0] r_rd_lo;
    logic [SAMPLE_W-1:0] r_rd_hi;
    logic [FRAC_W-1:0]   r_b_frac;
    logic                r_b_blend;
    logic [SAMPLE_W-1:0] r_b_merged;

    logic                up;
    logic [SAMPLE_W-1:0] diff;

    logic                r_c_vld;
    logic [PROD_W-1:0]   r_c_prod;
    logic                r_c_up;
    logic                r_c_blend;
    logic [SAMPLE_W-1:0] r_c_lo;
    logic [SAMPLE_W-1:0] r_c_merged;

    logic [PROD_W-1:0]   prod_ceil;
    logic [SAMPLE_W-1:0] res;

    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    assign adv        = !r_out_valid || i_ready;
    assign o_pop      = adv && !i_q_empty;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out_data;
    assign o_c_lookup = r_c_vld;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_cmd    <= i_head;
            r_a_scaled <= SCALED_W'(i_head.pos) * SCALED_W'(i_head.nm1);
        end
    end

    always_comb begin
        w0         = r_a_scaled[SCALED_W-1:FRAC_W];
        blend      = w0 < 8'(r_a_cmd.nm1);
        wsel       = blend ? w0 : 8'(r_a_cmd.nm1);
        rd_addr_lo = {BANK_W'(r_a_cmd.bank), WAVE_W'(wsel), r_a_cmd.addr};
        rd_addr_hi = {BANK_W'(r_a_cmd.bank), WAVE_W'(wsel + 8'd1), r_a_cmd.addr};
        wr_addr    = {BANK_W'(r_a_cmd.bank), WAVE_W'(r_a_cmd.wave), r_a_cmd.sample_idx};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_a_vld && r_a_cmd.is_load) begin
                r_mem[wr_addr] <= r_a_cmd.sample_val;
            end
            r_rd_lo <= r_mem[rd_addr_lo];
            r_rd_hi <= r_mem[rd_addr_hi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_frac   <= r_a_scaled[FRAC_W-1:0];
            r_b_blend  <= blend;
            r_b_merged <= r_a_cmd.merged;
        end
    end

    always_comb begin
        up   = r_rd_hi > r_rd_lo;
        diff = up ? (r_rd_hi - r_rd_lo) : (r_rd_lo - r_rd_hi);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_prod   <= PROD_W'(diff) * PROD_W'(r_b_frac);
            r_c_up     <= up;
            r_c_blend  <= r_b_blend;
            r_c_lo     <= r_rd_lo;
            r_c_merged <= r_b_merged;
        end
    end

    always_comb begin
        prod_ceil = r_c_prod + PROD_W'(16'hFFFF);
        if (!r_c_blend) begin
            res = r_c_lo;
        end else if (r_c_up) begin
            res = r_c_lo + r_c_prod[PROD_W-1:FRAC_W];
        end else begin
            res = r_c_lo - prod_ceil[PROD_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {r_c_merged, res};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_c_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_vld     <= !i_q_empty;
            r_b_vld     <= r_a_vld && !r_a_cmd.is_load;
            r_c_vld     <= r_b_vld;
            r_out_valid <= r_c_vld;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the wavetable crossfade lookup.
import wcl_pkg::*;

typedef struct {
    t_func                func;
    logic [BANK_IN_W-1:0] bank;
    logic [WAVE_IN_W-1:0] wave;
    logic [SAMPLE_W-1:0]  sample_idx;
    logic [SAMPLE_W-1:0]  sample_val;
    logic [TOTAL_W-1:0]   total;
    logic [POS_W-1:0]     pos;
    logic [7:0]           phase;
    logic [7:0]           poly;
    logic                 poly_on;
    logic [7:0]           single_gates;
    logic [7:0]           single_mask;
} wave_item;

typedef struct {
    logic [7:0] sample;
    logic [7:0] gates;
} lookup_result;

class lookup_scoreboard;
    logic [7:0]   wave_mem [int];
    int           bank_waves [DEF_NUM_BANKS];
    int           bank_reg;
    lookup_result pending_q [$];
    int           checked;
    int           errors;
    int           loads;
    int           count_writes;

    function void clear();
        pending_q.delete();
        wave_mem.delete();
        foreach (bank_waves[i]) bank_waves[i] = 1;
        bank_reg = 1;
    endfunction

    function int slot_key(int bank, int wave, int addr);
        return (bank * DEF_MAX_WAVES + wave) * WAVE_LEN + addr;
    endfunction

    // Resolve gates, address, bank and the wave pair a lookup reads.
    function void locate(input wave_item it, output int bank, output int wave,
                         output bit blend, output int frac, output int merged,
                         output int addr);
        int limit;
        int n;
        int pos;
        int scaled;
        merged = it.poly_on ? int'(it.poly) : 0;
        merged = ((merged & ~int'(it.single_mask)) | (it.single_gates & it.single_mask)) & 'hFF;
        addr = (merged + it.phase) & 'hFF;
        limit = bank_reg;
        if (limit < 1) limit = 1;
        if (limit > DEF_NUM_BANKS) limit = DEF_NUM_BANKS;
        bank = it.bank;
        if (bank >= limit) bank = limit - 1;
        n = bank_waves[bank];
        pos = it.pos;
        if (pos > 65536) pos = 65536;
        scaled = pos * (n - 1);
        wave = scaled >> FRAC_W;
        frac = scaled & 'hFFFF;
        if (wave > n - 1) wave = n - 1;
        blend = wave < n - 1;
    endfunction

    function void note_input(wave_item it);
        int bank;
        int wave;
        int frac;
        int merged;
        int addr;
        int lo;
        int hi;
        int res;
        bit blend;
        lookup_result want;
        case (it.func)
            FUNC_LOAD: begin
                wave_mem[slot_key(it.bank, it.wave, it.sample_idx)] = it.sample_val;
                loads++;
            end
            FUNC_COUNT: begin
                if (it.total < 1) bank_waves[it.bank] = 1;
                else if (it.total > DEF_MAX_WAVES) bank_waves[it.bank] = DEF_MAX_WAVES;
                else bank_waves[it.bank] = it.total;
                count_writes++;
            end
            FUNC_LOOKUP: begin
                locate(it, bank, wave, blend, frac, merged, addr);
                lo = wave_mem[slot_key(bank, wave, addr)];
                res = lo;
                if (blend) begin
                    hi = wave_mem[slot_key(bank, wave + 1, addr)];
                    // truncate the exact blend toward the lower byte
                    if (hi > lo) res = lo + (((hi - lo) * frac) >> FRAC_W);
                    else res = lo - (((lo - hi) * frac + 65535) >> FRAC_W);
                end
                want.sample = res[7:0];
                want.gates = merged[7:0];
                pending_q = {pending_q, want};
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] word);
        lookup_result want;
        logic [7:0]   got_sample;
        logic [7:0]   got_gates;
        got_sample = word[7:0];
        got_gates = word[15:8];
        if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: sample %h gates %h",
                                       got_sample, got_gates);
            return;
        end
        want = pending_q.pop_front();
        checked++;
        if (got_sample !== want.sample || got_gates !== want.gates) begin
            errors++;
            if (errors <= 10)
                $display("mismatch on result %0d: sample exp %h got %h, gates exp %h got %h",
                         checked, want.sample, got_sample, want.gates, got_gates);
        end
    endfunction
endclass

module tb_top;
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    lookup_scoreboard board = new();
    bit calm = 1'b0;
    int items_sent = 0;
    int cfg_writes = 0;

    wavetable_crossfade_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10000000;
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic wave_item make_item(t_func f);
        wave_item it;
        it.func = f;
        it.bank = '0;
        it.wave = '0;
        it.sample_idx = '0;
        it.sample_val = '0;
        it.total = '0;
        it.pos = '0;
        it.phase = '0;
        it.poly = '0;
        it.poly_on = 1'b0;
        it.single_gates = '0;
        it.single_mask = '0;
        return it;
    endfunction

    function automatic wave_item rand_item(t_func f);
        wave_item it;
        int r;
        it.func = f;
        it.bank = BANK_IN_W'($urandom_range(0, 15));
        it.wave = WAVE_IN_W'($urandom_range(0, 63));
        it.sample_idx = SAMPLE_W'($urandom_range(0, 255));
        it.sample_val = SAMPLE_W'($urandom_range(0, 255));
        it.total = TOTAL_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                        : $urandom_range(1, 64));
        r = $urandom_range(0, 9);
        if (r == 0) it.pos = '0;
        else if (r == 1) it.pos = 17'h10000;
        else if (r == 2) it.pos = 17'h0FFFF;
        else if (r == 3) it.pos = POS_W'($urandom_range(65537, 131071));
        else it.pos = POS_W'($urandom_range(0, 65536));
        it.phase = 8'($urandom_range(0, 255));
        it.poly = 8'($urandom_range(0, 255));
        it.poly_on = 1'($urandom_range(0, 1));
        it.single_gates = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 3);
        it.single_mask = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic wave_item look(int bank, int pos, int phase, int poly, bit poly_on,
                                      int single_gates, int single_mask);
        wave_item it;
        it = make_item(FUNC_LOOKUP);
        it.bank = BANK_IN_W'(bank);
        it.pos = POS_W'(pos);
        it.phase = 8'(phase);
        it.poly = 8'(poly);
        it.poly_on = poly_on;
        it.single_gates = 8'(single_gates);
        it.single_mask = 8'(single_mask);
        return it;
    endfunction

    task automatic send_item(wave_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.func;
        s_axis_tdata <= S_TDATA_W'({it.single_mask, it.single_gates, it.poly_on, it.poly,
                                    it.phase, it.pos, it.total, it.sample_val,
                                    it.sample_idx, it.wave, it.bank});
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input(it);
        items_sent++;
    endtask

    task automatic send_load(int bank, int wave, int idx, int val);
        wave_item it;
        it = make_item(FUNC_LOAD);
        it.bank = BANK_IN_W'(bank);
        it.wave = WAVE_IN_W'(wave);
        it.sample_idx = SAMPLE_W'(idx);
        it.sample_val = SAMPLE_W'(val);
        send_item(it);
    endtask

    task automatic send_count(int bank, int total);
        wave_item it;
        it = make_item(FUNC_COUNT);
        it.bank = BANK_IN_W'(bank);
        it.total = TOTAL_W'(total);
        send_item(it);
    endtask

    // Load any wave bytes the lookup will read that are still unwritten, then send the lookup.
    task automatic send_lookup(wave_item it);
        int  bank;
        int  wave;
        int  frac;
        int  merged;
        int  addr;
        bit  blend;
        board.locate(it, bank, wave, blend, frac, merged, addr);
        if (!board.wave_mem.exists(board.slot_key(bank, wave, addr)))
            send_load(bank, wave, addr, $urandom_range(0, 255));
        if (blend && !board.wave_mem.exists(board.slot_key(bank, wave + 1, addr)))
            send_load(bank, wave + 1, addr, $urandom_range(0, 255));
        send_item(it);
    endtask

    task automatic set_bank_count(int value);
        s_axis_tvalid <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= CFG_W'(value);
        @(posedge i_clk);
        board.bank_reg = value;
        i_cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
            if (stall > 0) stall--;
            else if ($urandom_range(0, 3) == 0) stall = pick_gap();
            m_axis_tready <= (stall == 0);
        end
    end

    initial begin
        int       settings [7];
        int       n;
        int       op;
        wave_item it;
        settings = '{16, 1, 0, 31, 8, 16, 3};
        settings[6] = $urandom_range(2, 15);
        board.clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_load(0, 0, 0, 8'h00);
        send_load(0, 0, 255, 8'hFF);
        send_lookup(look(0, 0, 0, 8'h5A, 1'b0, 0, 0));
        send_lookup(look(0, 0, 0, 8'hFF, 1'b1, 0, 0));
        send_lookup(look(0, 0, 8'hF1, 8'hF0, 1'b1, 8'h0F, 8'hFF));
        send_lookup(look(15, 17'h1FFFF, 8'h33, 8'hAA, 1'b1, 8'h05, 8'h0F));
        send_count(0, 0);
        send_count(0, 127);
        send_count(0, 2);
        send_load(0, 1, 0, 8'hFF);
        send_load(0, 1, 255, 8'h00);
        send_lookup(look(0, 17'h08000, 0, 0, 1'b0, 0, 0));
        send_lookup(look(0, 17'h0FFFF, 0, 0, 1'b0, 0, 0));
        send_lookup(look(0, 17'h10000, 0, 0, 1'b0, 0, 0));
        send_lookup(look(0, 17'h00001, 0, 8'hFF, 1'b1, 0, 0));
        it = make_item(FUNC_NONE);
        it.bank = '1;
        it.wave = '1;
        it.sample_idx = '1;
        it.sample_val = '1;
        it.total = '1;
        it.pos = '1;
        it.phase = '1;
        it.poly = '1;
        it.poly_on = 1'b1;
        it.single_gates = '1;
        it.single_mask = '1;
        send_item(it);
        send_load(15, 63, 255, 8'hAB);
        send_count(15, 64);
        set_bank_count(16);
        send_lookup(look(15, 17'h10000, 0, 8'hFF, 1'b1, 0, 0));
        send_lookup(look(15, 17'h0FFFF, 8'h01, 0, 1'b1, 8'hFF, 8'hFF));

        foreach (settings[p]) begin
            set_bank_count(settings[p]);
            calm = (p == 4);
            n = items_sent;
            while (items_sent - n < 230) begin
                op = $urandom_range(0, 99);
                if (op < 65) begin
                    send_lookup(rand_item(FUNC_LOOKUP));
                end else if (op < 82) begin
                    send_item(rand_item(FUNC_LOAD));
                end else if (op < 94) begin
                    send_item(rand_item(FUNC_COUNT));
                end else begin
                    send_item(rand_item(FUNC_NONE));
                end
            end
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("run covered %0d transfers in, %0d lookups checked, %0d sample loads,",
                 items_sent, board.checked, board.loads);
        $display("%0d wave count writes and %0d bank count settings; %0d errors",
                 board.count_writes, cfg_writes, board.errors);
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
